[rtl/stq_pkg.sv]
// stq_pkg: shared types and constants for the sorted timer queue
// no dependencies; used by the top level and the port checker
`default_nettype none

package stq_pkg;

	localparam int TIMER_SLOTS_DEF = 16;
	localparam int TIME_BITS_DEF   = 32;
	localparam int MAX_POPS        = 16;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_DEL  = 2'd1,
		OP_UPD  = 2'd2,
		OP_TICK = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ACTIVE   = 2'd1,
		ST_INACTIVE = 2'd2
	} status_t;

endpackage

`default_nettype wire

[rtl/stq_ram.sv]
// stq_ram: generic one-write one-read memory with registered read data
// no dependencies
`default_nettype none

module stq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

[rtl/sorted_timer_queue.sv]
// sorted_timer_queue: timers ordered by expiry in a circular list held in one ram
// add and delete scan the whole list, update stops once placed, rejects skip it
// tick pops due timers from the head, stalling while the output is held
// one request at a time; a result sits in the output register while the next is taken
// arst_n clears the active flags, list count, head pointer and sequencer
// depends on stq_pkg and stq_ram
`default_nettype none

module sorted_timer_queue #(
	parameter int TIMER_SLOTS = stq_pkg::TIMER_SLOTS_DEF,
	parameter int TIME_BITS   = stq_pkg::TIME_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [3:0]  slot,
	input  wire logic [31:0] expiry,
	input  wire logic [31:0] current_time,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic             expired_valid,
	output logic [3:0]       expired_slot,
	output logic             last
);

	localparam int SW = $clog2(TIMER_SLOTS);
	localparam int CW = $clog2(TIMER_SLOTS + 1);
	localparam int TW = (TIME_BITS < 32) ? TIME_BITS : 32;
	localparam int EW = SW + TW;
	localparam int NW = $clog2(stq_pkg::MAX_POPS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_TICK,
		S_RESP
	} state_t;

	state_t            state_q;
	stq_pkg::op_t      op_q;
	stq_pkg::status_t  res_status_q;
	logic [SW-1:0]     slot_q;
	logic [TW-1:0]     time_q;
	logic [TW-1:0]     now_q;
	logic [CW-1:0]     ci_q;
	logic [CW-1:0]     count_q;
	logic [SW-1:0]     head_q;
	logic              found_q;
	logic [EW-1:0]     carry_q;
	logic [NW-1:0]     n_q;
	logic              pend_q;
	logic [SW-1:0]     pend_slot_q;
	logic [TIMER_SLOTS-1:0] act_q;

	logic              out_valid_q;
	stq_pkg::status_t  out_status_q;
	logic              out_exp_q;
	logic [3:0]        out_slot_q;
	logic              out_last_q;

	logic [EW-1:0]     rd_data;
	logic [SW-1:0]     d_slot;
	logic [TW-1:0]     d_exp;
	logic [EW-1:0]     new_ent;
	logic              at_end;
	logic              later;
	logic              due;
	logic              out_free;
	logic              out_load;
	logic              wr_en;
	logic [CW-1:0]     wr_idx;
	logic [EW-1:0]     wr_data;
	logic [CW-1:0]     rd_idx;
	logic              in_range;
	logic [SW-1:0]     in_idx;

	function automatic logic [SW-1:0] phys(input logic [SW-1:0] base, input logic [CW-1:0] idx);
		logic [SW:0] sum;
		sum = (SW+1)'(base) + (SW+1)'(idx);
		if (sum >= (SW+1)'(TIMER_SLOTS)) begin
			sum = sum - (SW+1)'(TIMER_SLOTS);
		end
		return sum[SW-1:0];
	endfunction

	stq_ram #(
		.WIDTH(EW),
		.DEPTH(TIMER_SLOTS)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(phys(head_q, wr_idx)),
		.wr_data(wr_data),
		.rd_addr(phys(head_q, rd_idx)),
		.rd_data(rd_data)
	);

	assign d_slot   = rd_data[EW-1:TW];
	assign d_exp    = rd_data[TW-1:0];
	assign new_ent  = {slot_q, time_q};
	assign at_end   = (ci_q == count_q);
	assign later    = (time_q < d_exp);
	assign due      = (count_q != '0) && (n_q < NW'(stq_pkg::MAX_POPS)) && !(now_q < d_exp);
	assign out_free = !out_valid_q || out_ready;
	assign out_load = ((state_q == S_TICK) && out_free && (!due || pend_q))
		|| ((state_q == S_RESP) && out_free);
	assign in_range = (32'(slot) < 32'(TIMER_SLOTS));
	assign in_idx   = SW'(slot);

	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = ci_q;
		wr_data = new_ent;
		rd_idx  = ci_q + CW'(1);
		case (state_q)
			S_IDLE: begin
				rd_idx = '0;
			end
			S_SCAN: begin
				case (op_q)
					stq_pkg::OP_ADD: begin
						if (at_end) begin
							wr_en   = 1'b1;
							wr_data = found_q ? carry_q : new_ent;
						end else if (found_q) begin
							wr_en   = 1'b1;
							wr_data = carry_q;
						end else if (later) begin
							wr_en = 1'b1;
						end
					end
					stq_pkg::OP_DEL: begin
						wr_idx  = ci_q - CW'(1);
						wr_data = rd_data;
						wr_en   = !at_end && found_q;
					end
					stq_pkg::OP_UPD: begin
						wr_idx = ci_q - CW'(1);
						if (at_end) begin
							wr_en = 1'b1;
						end else if (found_q) begin
							wr_en   = 1'b1;
							wr_data = later ? new_ent : rd_data;
						end
					end
					default: begin
						wr_en = 1'b0;
					end
				endcase
			end
			S_TICK: begin
				rd_idx = (due && (!pend_q || out_free)) ? CW'(1) : CW'(0);
			end
			default: begin
				rd_idx = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= stq_pkg::OP_ADD;
			res_status_q <= stq_pkg::ST_OK;
			slot_q       <= '0;
			time_q       <= '0;
			now_q        <= '0;
			ci_q         <= '0;
			count_q      <= '0;
			head_q       <= '0;
			found_q      <= 1'b0;
			carry_q      <= '0;
			n_q          <= '0;
			pend_q       <= 1'b0;
			pend_slot_q  <= '0;
			act_q        <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= stq_pkg::ST_OK;
			out_exp_q    <= 1'b0;
			out_slot_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= stq_pkg::op_t'(op);
						slot_q  <= in_idx;
						time_q  <= TW'(expiry);
						now_q   <= TW'(current_time);
						ci_q    <= '0;
						found_q <= 1'b0;
						n_q     <= '0;
						pend_q  <= 1'b0;
						if (stq_pkg::op_t'(op) == stq_pkg::OP_TICK) begin
							state_q <= S_TICK;
						end else if (!in_range) begin
							res_status_q <= stq_pkg::ST_INACTIVE;
							state_q      <= S_RESP;
						end else if (stq_pkg::op_t'(op) == stq_pkg::OP_ADD && act_q[in_idx]) begin
							res_status_q <= stq_pkg::ST_ACTIVE;
							state_q      <= S_RESP;
						end else if (stq_pkg::op_t'(op) != stq_pkg::OP_ADD && !act_q[in_idx]) begin
							res_status_q <= stq_pkg::ST_INACTIVE;
							state_q      <= S_RESP;
						end else begin
							res_status_q <= stq_pkg::ST_OK;
							state_q      <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					ci_q <= ci_q + CW'(1);
					case (op_q)
						stq_pkg::OP_ADD: begin
							if (at_end) begin
								count_q       <= count_q + CW'(1);
								act_q[slot_q] <= 1'b1;
								state_q       <= S_RESP;
							end else if (found_q || later) begin
								carry_q <= rd_data;
								found_q <= 1'b1;
							end
						end
						stq_pkg::OP_DEL: begin
							if (at_end) begin
								count_q       <= count_q - CW'(1);
								act_q[slot_q] <= 1'b0;
								state_q       <= S_RESP;
							end else if (!found_q && d_slot == slot_q) begin
								found_q <= 1'b1;
							end
						end
						stq_pkg::OP_UPD: begin
							if (at_end || (found_q && later)) begin
								state_q <= S_RESP;
							end else if (!found_q && d_slot == slot_q) begin
								found_q <= 1'b1;
							end
						end
						default: begin
							state_q <= S_RESP;
						end
					endcase
				end
				S_TICK: begin
					if (due) begin
						if (pend_q && out_free) begin
							out_status_q <= stq_pkg::ST_OK;
							out_exp_q    <= 1'b1;
							out_slot_q   <= 4'(pend_slot_q);
							out_last_q   <= 1'b0;
						end
						if (!pend_q || out_free) begin
							pend_q        <= 1'b1;
							pend_slot_q   <= d_slot;
							n_q           <= n_q + NW'(1);
							head_q        <= phys(head_q, CW'(1));
							count_q       <= count_q - CW'(1);
							act_q[d_slot] <= 1'b0;
						end
					end else if (out_free) begin
						out_status_q <= stq_pkg::ST_OK;
						out_exp_q    <= pend_q;
						out_slot_q   <= pend_q ? 4'(pend_slot_q) : 4'd0;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_exp_q    <= 1'b0;
						out_slot_q   <= 4'd0;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign expired_valid = out_exp_q;
	assign expired_slot  = out_slot_q;
	assign last          = out_last_q;

endmodule

`default_nettype wire

[rtl/stq_checker.sv]
// stq_checker: port-level assertions for the sorted timer queue, bound to the top level
// depends on stq_pkg and sorted_timer_queue
`default_nettype none

module stq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  status,
	input wire logic        expired_valid,
	input wire logic [3:0]  expired_slot,
	input wire logic        last
);

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(expired_valid)
			&& $stable(expired_slot) && $stable(last))
		else $error("result changed while stalled");

	// a request is worked on before the next is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// error status only on single status results
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 2'(stq_pkg::ST_OK) |-> !expired_valid && last)
		else $error("error status on expiry result");

	// a result with no expiry closes its request and carries slot zero
	a_noexp_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !expired_valid |-> last && expired_slot == 4'd0)
		else $error("malformed non-expiry result");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (.*);

`default_nettype wire
